// ===== rtl/swmh_pkg.sv =====
// ----------------------------------------------------------------------------
// swmh_pkg
// shared widths and constants of the sliding window minimiser hash core
// ----------------------------------------------------------------------------
`default_nettype none

package swmh_pkg;

    localparam int HASH_W         = 64;
    localparam int WBITS_W        = 2;
    localparam int CFG_W          = 7;
    localparam int CFG_RESET      = 16;
    localparam int MAX_WINDOW_DEF = 64;

    localparam logic [HASH_W-1:0] HASH_ONES = '1;

endpackage

`default_nettype wire

// ===== rtl/swmh_ring.sv =====
// ----------------------------------------------------------------------------
// swmh_ring
// ring store, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module swmh_ring #(
    parameter int DEPTH  = swmh_pkg::MAX_WINDOW_DEF,
    parameter int WIDTH  = swmh_pkg::HASH_W,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/sliding_window_minimiser_hash_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_minimiser_hash_core
// minimum-tracking window over a stream of sub-string hashes
// ----------------------------------------------------------------------------
// Each input word writes its selection hash and payload hash into two ring
// memories and returns one word: the payload hash at the current minimum,
// shifted left by two, with the window bits below it. A word passes through
// accept, ring read and result. When the slot being overwritten holds the
// current minimum, the selection ring's single read port walks every filled
// slot, one per cycle, before the ring read of that word. A new word is taken
// while a result still waits in the output register. Writing the window
// length restarts the window.
`default_nettype none

module sliding_window_minimiser_hash_core #(
    parameter int MAX_WINDOW = swmh_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [swmh_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [swmh_pkg::HASH_W-1:0]   i_select_hash,
    input  wire logic [swmh_pkg::HASH_W-1:0]   i_payload_hash,
    input  wire logic [swmh_pkg::WBITS_W-1:0]  i_window_bits,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [swmh_pkg::HASH_W-1:0]   o_minimiser_hash
);

    import swmh_pkg::*;

    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int LEN_W  = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_SCAN_END = 3'd2;
    localparam logic [2:0] ST_RD       = 3'd3;
    localparam logic [2:0] ST_RES      = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_len, n_len;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [SLOT_W-1:0]  r_wslot, n_wslot;
    logic [SLOT_W-1:0]  r_min_slot, n_min_slot;
    logic [HASH_W-1:0]  r_min_value, n_min_value;
    logic [SLOT_W-1:0]  r_idx, n_idx;
    logic [SLOT_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic               r_cmp_vld, n_cmp_vld;
    logic [WBITS_W-1:0] r_wbits, n_wbits;
    logic               r_out_valid, n_out_valid;
    logic [HASH_W-1:0]  r_out_hash, n_out_hash;

    logic [LEN_W-1:0]   cfg_ext;
    logic [CNT_W-1:0]   cfg_len;
    logic [SLOT_W-1:0]  slot;
    logic [CNT_W-1:0]   slot_inc;
    logic               in_acc;
    logic               out_free;
    logic [HASH_W-1:0]  sel_q;
    logic [HASH_W-1:0]  pay_q;

    // window length clamped to 1..MAX_WINDOW
    always_comb begin
        cfg_ext = LEN_W'(i_cfg_data);
        if (cfg_ext == '0) begin
            cfg_len = CNT_W'(1);
        end else if (cfg_ext > LEN_W'(MAX_WINDOW)) begin
            cfg_len = CNT_W'(MAX_WINDOW);
        end else begin
            cfg_len = CNT_W'(cfg_ext);
        end
    end

    assign o_in_stall       = (r_state != ST_IDLE) || !i_rst_n;
    assign in_acc           = i_in_valid && !o_in_stall;
    assign out_free         = !r_out_valid || !i_out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_minimiser_hash = r_out_hash;

    assign slot     = (CNT_W'(r_wslot) >= r_len) ? '0 : r_wslot;
    assign slot_inc = CNT_W'(slot) + CNT_W'(1);

    swmh_ring #(
        .DEPTH  (MAX_WINDOW),
        .WIDTH  (HASH_W),
        .ADDR_W (SLOT_W)
    ) u_select_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (slot),
        .i_wdata (i_select_hash),
        .i_raddr (r_idx),
        .o_rdata (sel_q)
    );

    swmh_ring #(
        .DEPTH  (MAX_WINDOW),
        .WIDTH  (HASH_W),
        .ADDR_W (SLOT_W)
    ) u_payload_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (slot),
        .i_wdata (i_payload_hash),
        .i_raddr (r_min_slot),
        .o_rdata (pay_q)
    );

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_fill      = r_fill;
        n_wslot     = r_wslot;
        n_min_slot  = r_min_slot;
        n_min_value = r_min_value;
        n_idx       = r_idx;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_vld   = r_cmp_vld;
        n_wbits     = r_wbits;
        n_out_valid = r_out_valid;
        n_out_hash  = r_out_hash;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // rescan compare of the word read in the previous cycle
        if ((r_state == ST_SCAN || r_state == ST_SCAN_END) && r_cmp_vld) begin
            if (sel_q < r_min_value) begin
                n_min_slot  = r_cmp_idx;
                n_min_value = sel_q;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_wbits = i_window_bits;
                    if (r_fill < r_len) begin
                        n_fill = r_fill + CNT_W'(1);
                    end else begin
                        n_fill = r_len;
                    end
                    n_wslot = (slot_inc >= r_len) ? '0 : SLOT_W'(slot_inc);
                    if (r_min_slot == slot) begin
                        n_min_slot  = '0;
                        n_min_value = HASH_ONES;
                        n_idx       = '0;
                        n_cmp_vld   = 1'b0;
                        n_state     = ST_SCAN;
                    end else begin
                        if (i_select_hash < r_min_value) begin
                            n_min_slot  = slot;
                            n_min_value = i_select_hash;
                        end
                        n_state = ST_RD;
                    end
                end
            end
            ST_SCAN: begin
                n_cmp_idx = r_idx;
                n_cmp_vld = 1'b1;
                if (CNT_W'(r_idx) + CNT_W'(1) == r_fill) begin
                    n_state = ST_SCAN_END;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            ST_SCAN_END: begin
                n_cmp_vld = 1'b0;
                n_state   = ST_RD;
            end
            ST_RD: begin
                n_state = ST_RES;
            end
            ST_RES: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hash  = {pay_q[HASH_W-WBITS_W-1:0], r_wbits};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // window restart on a length write
        if (i_cfg_we) begin
            n_len       = cfg_len;
            n_fill      = '0;
            n_wslot     = '0;
            n_min_slot  = '0;
            n_min_value = HASH_ONES;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= CNT_W'((CFG_RESET > MAX_WINDOW) ? MAX_WINDOW : CFG_RESET);
            r_fill      <= '0;
            r_wslot     <= '0;
            r_min_slot  <= '0;
            r_min_value <= HASH_ONES;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_fill      <= n_fill;
            r_wslot     <= n_wslot;
            r_min_slot  <= n_min_slot;
            r_min_value <= n_min_value;
            r_idx       <= n_idx;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= n_cmp_idx;
        r_wbits    <= n_wbits;
        r_out_hash <= n_out_hash;
    end

endmodule

`default_nettype wire

// ===== rtl/swmh_checker.sv =====
// ----------------------------------------------------------------------------
// swmh_checker
// port-level checks of the sliding window minimiser hash core
// ----------------------------------------------------------------------------
`default_nettype none

module swmh_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [swmh_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    input  wire logic                          o_in_stall,
    input  wire logic [swmh_pkg::HASH_W-1:0]   i_select_hash,
    input  wire logic [swmh_pkg::HASH_W-1:0]   i_payload_hash,
    input  wire logic [swmh_pkg::WBITS_W-1:0]  i_window_bits,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic [swmh_pkg::HASH_W-1:0]   o_minimiser_hash
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pend;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // words accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (in_acc && !out_acc) begin
            r_pend <= r_pend + 2'd1;
        end else if (out_acc && !in_acc) begin
            r_pend <= r_pend - 2'd1;
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken while a word is in work");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 2'd2)
        else $error("more than two words outstanding");

    a_out_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != 2'd0)
        else $error("result without an accepted word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_minimiser_hash)))
        else $error("stalled result changed");

endmodule

bind sliding_window_minimiser_hash_core swmh_checker u_swmh_checker (.*);

`default_nettype wire
